// File: sv/vertex_normal_transform_core_defines.svh
// Assertion macros for the vertex normal transform core
`ifndef VERTEX_NORMAL_TRANSFORM_CORE_DEFINES_SVH
`define VERTEX_NORMAL_TRANSFORM_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VNT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define VNT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VNT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define VNT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/vnt_pkg.sv
// ----------------------------------------------------------------------------
// vnt_pkg
// Shared types and constants of the vertex normal transform core.
// ----------------------------------------------------------------------------
package vnt_pkg;
    localparam int NUM_ROWS = 4;
    localparam int SLOT_W   = 16;
    localparam int DATA_W   = 32;
    localparam int NMAT_N   = 9;
    localparam int CFG_IDX_W = 2;
    localparam logic signed [DATA_W-1:0] NM_ONE = 32'sh0001_0000;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_COF,
        DS_DIV
    } derive_state_t;

    typedef struct packed {
        logic start;
    } derive_ctrl_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [79:0] v);
        if (v > 80'sd2147483647)
            return 32'sh7fff_ffff;
        else if (v < -80'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[DATA_W-1:0];
    endfunction
endpackage

// File: sv/vnt_derive.sv
// ----------------------------------------------------------------------------
// vnt_derive
// Derives the normal matrix (cofactors over determinant) with a shared
// restoring divider, one quotient bit per cycle, one entry after another.
// ----------------------------------------------------------------------------
module vnt_derive #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vnt_pkg::derive_ctrl_t               ctrl,
    input  logic [4*vnt_pkg::SLOT_W-1:0]        row0,
    input  logic [4*vnt_pkg::SLOT_W-1:0]        row1,
    input  logic [4*vnt_pkg::SLOT_W-1:0]        row2,
    output logic                                busy,
    output logic signed [vnt_pkg::DATA_W-1:0]   nmat [vnt_pkg::NMAT_N],
    output logic                                singular
);
    import vnt_pkg::*;

    localparam int PW  = 2 * COEF_WIDTH + 1;
    localparam int DW  = 3 * COEF_WIDTH + 3;
    localparam int NUMW = PW + 29;
    localparam int QB  = 33;

    derive_state_t state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [3:0] ent_reg, ent_next;
    logic [5:0] bit_reg, bit_next;
    logic signed [COEF_WIDTH-1:0] a [3][3];
    logic signed [PW-1:0] cf_reg [9];
    logic signed [DW-1:0] det_reg;
    logic signed [2*COEF_WIDTH-1:0] prod_reg [2];
    logic [NUMW+QB-1:0] rem_reg, rem_next;
    logic [QB-1:0] q_reg, q_next;
    logic q_ovf_reg, q_ovf_next;
    logic signed [DATA_W-1:0] nmat_reg [NMAT_N];
    logic singular_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (r == 0)
                    a[r][c] = row0[c*SLOT_W +: COEF_WIDTH];
                else if (r == 1)
                    a[r][c] = row1[c*SLOT_W +: COEF_WIDTH];
                else
                    a[r][c] = row2[c*SLOT_W +: COEF_WIDTH];
            end
        end
    end

    logic [1:0] ai0, aj0, ai1, aj1, ai2, aj2, ai3, aj3;
    always_comb
    begin
        ai0 = 2'd0; aj0 = 2'd0; ai1 = 2'd0; aj1 = 2'd0;
        ai2 = 2'd0; aj2 = 2'd0; ai3 = 2'd0; aj3 = 2'd0;
        unique case (step_reg)
            4'd0: begin ai0=2'd1; aj0=2'd1; ai1=2'd2; aj1=2'd2;
                        ai2=2'd1; aj2=2'd2; ai3=2'd2; aj3=2'd1; end
            4'd1: begin ai0=2'd1; aj0=2'd2; ai1=2'd2; aj1=2'd0;
                        ai2=2'd1; aj2=2'd0; ai3=2'd2; aj3=2'd2; end
            4'd2: begin ai0=2'd1; aj0=2'd0; ai1=2'd2; aj1=2'd1;
                        ai2=2'd1; aj2=2'd1; ai3=2'd2; aj3=2'd0; end
            4'd3: begin ai0=2'd0; aj0=2'd2; ai1=2'd2; aj1=2'd1;
                        ai2=2'd0; aj2=2'd1; ai3=2'd2; aj3=2'd2; end
            4'd4: begin ai0=2'd0; aj0=2'd0; ai1=2'd2; aj1=2'd2;
                        ai2=2'd0; aj2=2'd2; ai3=2'd2; aj3=2'd0; end
            4'd5: begin ai0=2'd0; aj0=2'd1; ai1=2'd2; aj1=2'd0;
                        ai2=2'd0; aj2=2'd0; ai3=2'd2; aj3=2'd1; end
            4'd6: begin ai0=2'd0; aj0=2'd1; ai1=2'd1; aj1=2'd2;
                        ai2=2'd0; aj2=2'd2; ai3=2'd1; aj3=2'd1; end
            4'd7: begin ai0=2'd0; aj0=2'd2; ai1=2'd1; aj1=2'd0;
                        ai2=2'd0; aj2=2'd0; ai3=2'd1; aj3=2'd2; end
            4'd8: begin ai0=2'd0; aj0=2'd0; ai1=2'd1; aj1=2'd1;
                        ai2=2'd0; aj2=2'd1; ai3=2'd1; aj3=2'd0; end
            default: ;
        endcase
    end

    // sign/magnitude of current entry during division
    logic signed [PW-1:0] cf_cur;
    logic [PW-1:0] mc;
    logic [DW-1:0] md;
    logic neg;
    logic [QB-1:0] uq;
    logic signed [DATA_W+1:0] sq;
    logic [1:0] det_col;

    always_comb
    begin
        cf_cur  = cf_reg[ent_reg];
        neg     = cf_cur[PW-1] != det_reg[DW-1];
        mc      = cf_cur[PW-1] ? PW'(-cf_cur) : PW'(cf_cur);
        md      = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
        uq      = (q_ovf_reg || q_reg > 33'h0_8000_0000) ? 33'h0_8000_0000 : q_reg;
        sq      = neg ? -$signed({1'b0, uq}) : $signed({1'b0, uq});
        det_col = 2'(step_reg - 4'd11);
    end

    // rounding folded in: numerator = mc*2^28 + md/2
    logic [NUMW+QB-1:0] num_init;
    assign num_init = ((NUMW+QB)'(mc) << 28) + (NUMW+QB)'(md >> 1);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        ent_next   = ent_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        q_ovf_next = q_ovf_reg;
        unique case (state_reg)
            DS_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = DS_COF;
                    step_next  = 4'd0;
                end
            end
            DS_COF:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd13)
                begin
                    ent_next = 4'd0;
                    bit_next = 6'd0;
                    state_next = DS_DIV;
                end
            end
            DS_DIV:
            begin
                if (bit_reg == 6'd0)
                begin
                    rem_next   = num_init;
                    q_next     = '0;
                    q_ovf_next = 1'b0;
                    bit_next   = 6'd1;
                end
                else if (bit_reg <= 6'(NUMW))
                begin
                    // long division over the numerator bits, msb first
                    q_next = {q_reg[QB-2:0], 1'b0};
                    q_ovf_next = q_ovf_reg || q_reg[QB-1];
                    rem_next = rem_reg;
                    if ((rem_reg >> (NUMW - int'(bit_reg))) >= (NUMW+QB)'(md))
                    begin
                        rem_next = rem_reg - ((NUMW+QB)'(md) << (NUMW - int'(bit_reg)));
                        q_next[0] = 1'b1;
                    end
                    bit_next = bit_reg + 6'd1;
                end
                else
                begin
                    bit_next = 6'd0;
                    if (ent_reg == 4'd8)
                        state_next = DS_IDLE;
                    else
                        ent_next = ent_reg + 4'd1;
                end
            end
            default: state_next = DS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= DS_COF;
            step_reg     <= 4'd0;
            ent_reg      <= 4'd0;
            bit_reg      <= 6'd0;
            singular_reg <= 1'b0;
            for (int k = 0; k < NMAT_N; k++)
                nmat_reg[k] <= (k % 4 == 0) ? NM_ONE : '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ent_reg   <= ent_next;
            bit_reg   <= bit_next;
            if (state_reg == DS_DIV && bit_reg > 6'(NUMW))
                nmat_reg[ent_reg] <= (det_reg == '0) ? '0 : sat32(80'(sq));
            // determinant is complete once division starts
            if (state_reg == DS_DIV && ent_reg == 4'd0 && bit_reg == 6'd0)
                singular_reg <= (det_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        q_ovf_reg <= q_ovf_next;
        if (state_reg == DS_COF)
        begin
            // two products per cycle, then subtract
            if (step_reg <= 4'd8)
            begin
                prod_reg[0] <= a[ai0][aj0] * a[ai1][aj1];
                prod_reg[1] <= a[ai2][aj2] * a[ai3][aj3];
            end
            if (step_reg >= 4'd1 && step_reg <= 4'd9)
                cf_reg[step_reg - 4'd1] <= PW'(prod_reg[0]) - PW'(prod_reg[1]);
            if (step_reg == 4'd10)
                det_reg <= '0;
            if (step_reg >= 4'd11 && step_reg <= 4'd13)
                det_reg <= det_reg + DW'(a[0][det_col]) * DW'(cf_reg[4'(det_col)]);
        end
    end

    assign busy     = state_reg != DS_IDLE;
    assign nmat     = nmat_reg;
    assign singular = singular_reg;
endmodule

// File: sv/vertex_normal_transform_core.sv
// ----------------------------------------------------------------------------
// vertex_normal_transform_core
// Transforms a vertex position by a 4x4 Q4.12 matrix and its normal by the
// inverse transpose of the upper 3x3, with 32-bit saturation.
// ----------------------------------------------------------------------------
// One vertex per cycle, while out_ready does not hold the output, through a
// four-stage pipeline (products, partial sums, final sum, rounding/saturation).
// A matrix write is taken only when the pipeline is empty and the divider idle.
// After reset and after each matrix write the normal matrix is rebuilt by a
// serial divider; no vertex is taken meanwhile.
`include "vertex_normal_transform_core_defines.svh"
module vertex_normal_transform_core #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [vnt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [31:0]  pos_w,
    input  logic signed [31:0]  nrm_x,
    input  logic signed [31:0]  nrm_y,
    input  logic signed [31:0]  nrm_z,
    input  logic                last_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  out_x,
    output logic signed [31:0]  out_y,
    output logic signed [31:0]  out_z,
    output logic signed [31:0]  out_w,
    output logic signed [31:0]  out_nx,
    output logic signed [31:0]  out_ny,
    output logic signed [31:0]  out_nz,
    output logic                last_out,
    output logic                singular
);
    import vnt_pkg::*;

    localparam int NST = 4;

    logic [63:0] row_reg [NUM_ROWS];
    logic cfg_hit;
    logic der_busy;
    logic signed [DATA_W-1:0] nmat [NMAT_N];
    logic der_sing;
    derive_ctrl_t dctl;
    logic [NST-1:0] v_reg;

    assign cfg_ready = !der_busy && (v_reg == '0);
    assign cfg_hit   = cfg_valid && cfg_ready;
    assign dctl.start = cfg_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
                row_reg[r] <= 64'(64'd4096 << (16 * r));
        end
        else if (cfg_hit)
        begin
            row_reg[cfg_index] <= cfg_data;
        end
    end

    vnt_derive #(.COEF_WIDTH(COEF_WIDTH)) u_derive (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (dctl),
        .row0     (row_reg[0]),
        .row1     (row_reg[1]),
        .row2     (row_reg[2]),
        .busy     (der_busy),
        .nmat     (nmat),
        .singular (der_sing)
    );

    logic [NST-1:0] adv;
    always_comb
    begin
        adv[NST-1] = !v_reg[NST-1] || out_ready;
        for (int s = NST - 2; s >= 0; s--)
            adv[s] = !v_reg[s] || adv[s+1];
    end
    assign in_ready = adv[0] && !der_busy && !cfg_hit;

    logic signed [COEF_WIDTH-1:0] m [4][4];
    always_comb
    begin
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = row_reg[r][c*SLOT_W +: COEF_WIDTH];
    end

    logic signed [31:0] p_in [4];
    logic signed [31:0] n_in [3];
    assign p_in[0] = pos_x; assign p_in[1] = pos_y;
    assign p_in[2] = pos_z; assign p_in[3] = pos_w;
    assign n_in[0] = nrm_x; assign n_in[1] = nrm_y; assign n_in[2] = nrm_z;

    // stage 1: products
    logic signed [47:0] pp_reg [4][4];
    logic signed [63:0] np_reg [3][3];
    // stage 2: pairwise sums
    logic signed [49:0] ps_reg [4][2];
    logic signed [49:0] nq_reg [3][2];
    logic signed [49:0] nq2_reg [3];
    logic [17:0] nr_reg [3];
    // stage 3: totals
    logic signed [50:0] pt_reg [4];
    logic signed [50:0] nt_reg [3];
    // stage 4: output
    logic signed [31:0] o_reg [7];
    logic [NST-1:0] last_reg;
    logic sing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (adv[0])
                v_reg[0] <= in_valid && in_ready;
            for (int s = 1; s < NST; s++)
                if (adv[s])
                    v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    pp_reg[r][c] <= 48'(m[r][c]) * 48'(p_in[c]);
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    np_reg[r][c] <= 64'(nmat[r*3+c]) * 64'(n_in[c]);
            last_reg[0] <= last_in;
        end
        if (adv[1])
        begin
            for (int r = 0; r < 4; r++)
            begin
                ps_reg[r][0] <= 50'(pp_reg[r][0]) + 50'(pp_reg[r][1]);
                ps_reg[r][1] <= 50'(pp_reg[r][2]) + 50'(pp_reg[r][3]);
            end
            for (int r = 0; r < 3; r++)
            begin
                nq_reg[r][0] <= 50'(np_reg[r][0] >>> 16) + 50'(np_reg[r][1] >>> 16);
                nq2_reg[r]   <= 50'(np_reg[r][2] >>> 16);
                nr_reg[r]    <= 18'(np_reg[r][0][15:0]) + 18'(np_reg[r][1][15:0])
                              + 18'(np_reg[r][2][15:0]);
                nq_reg[r][1] <= '0;
            end
            last_reg[1] <= last_reg[0];
        end
        if (adv[2])
        begin
            for (int r = 0; r < 4; r++)
                pt_reg[r] <= 51'(ps_reg[r][0]) + 51'(ps_reg[r][1]) + 51'sd2048;
            for (int r = 0; r < 3; r++)
                nt_reg[r] <= 51'(nq_reg[r][0]) + 51'(nq2_reg[r])
                           + 51'(signed'({1'b0, nr_reg[r]} + 19'd32768) >>> 16)
                           + 51'(nq_reg[r][1]);
            last_reg[2] <= last_reg[1];
        end
        if (adv[3])
        begin
            for (int r = 0; r < 4; r++)
                o_reg[r] <= sat32(80'(pt_reg[r] >>> 12));
            for (int r = 0; r < 3; r++)
                o_reg[4+r] <= sat32(80'(nt_reg[r]));
            last_reg[3] <= last_reg[2];
            sing_reg <= der_sing;
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_x  = o_reg[0];
    assign out_y  = o_reg[1];
    assign out_z  = o_reg[2];
    assign out_w  = o_reg[3];
    assign out_nx = o_reg[4];
    assign out_ny = o_reg[5];
    assign out_nz = o_reg[6];
    assign last_out = last_reg[3];
    assign singular = sing_reg;

    `VNT_ASSERT_IMPL(a_no_in_busy, clk, rst_n, der_busy, !in_ready)
    `VNT_ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid && !out_ready, out_valid)
    `VNT_ASSERT_NEXT(a_cfg_busy, clk, rst_n, cfg_hit, der_busy)
endmodule

// File: bench/tb_vertex_normal_transform_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_normal_transform_core
// Streams vertices through the transform core under several matrix settings,
// predicts position and normal results in the bench, compares each
// transaction.
// ----------------------------------------------------------------------------
module tb_vertex_normal_transform_core;
    import vnt_pkg::*;

    typedef struct {
        logic signed [31:0] px, py, pz, pw, nx, ny, nz;
        logic               last;
    } vertex_t;

    typedef struct {
        logic signed [31:0] x, y, z, w, nx, ny, nz;
        logic               last, sing;
    } xform_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ROW0 = 0, ROW1 = 1, ROW2 = 2, ROW3 = 3;

    logic               clk, rst_n;
    logic               cfg_valid, cfg_ready;
    logic [1:0]         cfg_index;
    logic [63:0]        cfg_data;
    logic               in_valid, in_ready;
    logic signed [31:0] pos_x, pos_y, pos_z, pos_w, nrm_x, nrm_y, nrm_z;
    logic               last_in;
    logic               out_valid, out_ready;
    logic signed [31:0] out_x, out_y, out_z, out_w, out_nx, out_ny, out_nz;
    logic               last_out, singular;

    vertex_t            vertex_backlog[$];
    xform_t             pending_results[$];
    logic [63:0]        mat_rows[4];
    logic signed [31:0] nmat[9];
    logic               nmat_singular;
    logic               in_fired;
    logic               squeeze_req, squeeze_taken;
    int                 fail_count;
    int                 idle_cycles;
    int                 in_gap, out_hold;
    logic               burst_mode;

    vertex_normal_transform_core DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic longint coef_at(int r, int c);
        logic signed [15:0] e;
        e = mat_rows[r][16*c +: 16];
        return longint'(e);
    endfunction

    function automatic void rebuild_normal_matrix();
        longint            a[3][3];
        longint            cf[3][3];
        longint            det;
        longint unsigned   mc, md, uq;
        logic              neg;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                a[i][j] = coef_at(i, j);
        cf[0][0] = a[1][1] * a[2][2] - a[1][2] * a[2][1];
        cf[0][1] = a[1][2] * a[2][0] - a[1][0] * a[2][2];
        cf[0][2] = a[1][0] * a[2][1] - a[1][1] * a[2][0];
        cf[1][0] = a[0][2] * a[2][1] - a[0][1] * a[2][2];
        cf[1][1] = a[0][0] * a[2][2] - a[0][2] * a[2][0];
        cf[1][2] = a[0][1] * a[2][0] - a[0][0] * a[2][1];
        cf[2][0] = a[0][1] * a[1][2] - a[0][2] * a[1][1];
        cf[2][1] = a[0][2] * a[1][0] - a[0][0] * a[1][2];
        cf[2][2] = a[0][0] * a[1][1] - a[0][1] * a[1][0];
        det = a[0][0] * cf[0][0] + a[0][1] * cf[0][1] + a[0][2] * cf[0][2];
        nmat_singular = (det == 0);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                if (det == 0)
                begin
                    nmat[i*3+j] = '0;
                end
                else
                begin
                    neg = (cf[i][j] < 0) != (det < 0);
                    mc  = (cf[i][j] < 0) ? -cf[i][j] : cf[i][j];
                    md  = (det < 0) ? -det : det;
                    uq  = ((mc << 28) + md / 2) / md;
                    if (uq > 64'h8000_0000)
                        uq = 64'h8000_0000;
                    nmat[i*3+j] = clamp32(neg ? -longint'(uq) : longint'(uq));
                end
            end
    endfunction

    function automatic xform_t transform_vertex(vertex_t v);
        xform_t r;
        longint p[4];
        longint n[3];
        longint acc, prod, qs, rs;
        longint res[7];
        p = '{longint'(v.px), longint'(v.py), longint'(v.pz), longint'(v.pw)};
        n = '{longint'(v.nx), longint'(v.ny), longint'(v.nz)};
        for (int i = 0; i < 4; i++)
        begin
            acc = 0;
            for (int j = 0; j < 4; j++)
                acc += coef_at(i, j) * p[j];
            res[i] = (acc + 2048) >>> 12;
        end
        for (int i = 0; i < 3; i++)
        begin
            qs = 0;
            rs = 0;
            for (int j = 0; j < 3; j++)
            begin
                prod = longint'(nmat[i*3+j]) * n[j];
                qs += prod >>> 16;
                rs += longint'(prod[15:0]);
            end
            res[4+i] = qs + ((rs + 32768) >>> 16);
        end
        r.x  = clamp32(res[0]);
        r.y  = clamp32(res[1]);
        r.z  = clamp32(res[2]);
        r.w  = clamp32(res[3]);
        r.nx = clamp32(res[4]);
        r.ny = clamp32(res[5]);
        r.nz = clamp32(res[6]);
        r.last = v.last;
        r.sing = nmat_singular;
        return r;
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 1)) ? 32'h7fff_ffff : 32'h8000_0000;
            1: return $urandom_range(0, 3) - 1;
            2, 3, 4: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
            1: return 16'h0000;
            2, 3, 4, 5: return $urandom_range(0, 16384) - 8192;
            default: return $urandom;
        endcase
    endfunction

    function automatic vertex_t rand_vertex();
        vertex_t v;
        v.px = rand_coord();
        v.py = rand_coord();
        v.pz = rand_coord();
        v.pw = rand_coord();
        v.nx = rand_coord();
        v.ny = rand_coord();
        v.nz = rand_coord();
        v.last = ($urandom_range(0, 7) == 0);
        return v;
    endfunction

    function automatic int pick_gap();
        if (burst_mode)
            return 0;
        case ($urandom_range(0, 19))
            0: return $urandom_range(10, 40);
            1, 2, 3, 4, 5, 6, 7: return $urandom_range(1, 3);
            default: return 0;
        endcase
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(in_valid && !in_fired))
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (vertex_backlog.size() > 0)
                begin
                    vertex_t v;
                    v = vertex_backlog.pop_front();
                    pos_x <= v.px;
                    pos_y <= v.py;
                    pos_z <= v.pz;
                    pos_w <= v.pw;
                    nrm_x <= v.nx;
                    nrm_y <= v.ny;
                    nrm_z <= v.nz;
                    last_in <= v.last;
                    in_valid <= 1'b1;
                    in_gap <= pick_gap();
                    if ($urandom_range(0, 49) == 0)
                        burst_mode <= ~burst_mode;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_hold > 0)
            begin
                out_hold <= out_hold - 1;
                out_ready <= 1'b0;
            end
            else if (squeeze_req && !squeeze_taken)
            begin
                squeeze_taken <= 1'b1;
                out_hold <= 300;
                out_ready <= 1'b0;
            end
            else if (burst_mode)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0: begin out_hold <= $urandom_range(10, 40); out_ready <= 1'b0; end
                    1, 2, 3, 4: begin out_hold <= $urandom_range(0, 2); out_ready <= 1'b0; end
                    default: out_ready <= 1'b1;
                endcase
            end
        end
    end

    // monitor and model update
    always @(posedge clk)
    begin
        xform_t e;
        in_fired <= in_valid && in_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                mat_rows[cfg_index] = cfg_data;
                rebuild_normal_matrix();
            end
            if (in_valid && in_ready)
                pending_results.push_back(transform_vertex(vertex_t'{pos_x, pos_y, pos_z,
                                                           pos_w, nrm_x, nrm_y, nrm_z,
                                                           last_in}));
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected output transaction");
                    fail_count++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    check_field("out_x", e.x, out_x);
                    check_field("out_y", e.y, out_y);
                    check_field("out_z", e.z, out_z);
                    check_field("out_w", e.w, out_w);
                    check_field("out_nx", e.nx, out_nx);
                    check_field("out_ny", e.ny, out_ny);
                    check_field("out_nz", e.nz, out_nz);
                    check_field("last_out", e.last, last_out);
                    check_field("singular", e.sing, singular);
                end
            end
            if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("vertex_normal_transform_core verification failed");
                $finish;
            end
        end
    end

    // cfg_ready is stable from the falling edge to the next rising edge
    task automatic write_row(int idx, logic [63:0] value);
        @(negedge clk);
        cfg_index <= idx[1:0];
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (vertex_backlog.size() > 0 || in_valid || pending_results.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [63:0] fill_row(logic [15:0] e);
        return {e, e, e, e};
    endfunction

    initial
    begin
        logic [63:0] r[4];
        logic signed [31:0] ext[4];
        vertex_t v;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        {pos_x, pos_y, pos_z, pos_w, nrm_x, nrm_y, nrm_z} = '0;
        last_in = 1'b0;
        in_fired = 1'b0;
        squeeze_req = 1'b0;
        squeeze_taken = 1'b0;
        fail_count = 0;
        idle_cycles = 0;
        in_gap = 0;
        out_hold = 0;
        burst_mode = 1'b0;
        mat_rows = '{64'd4096, 64'd4096 << 16, 64'd4096 << 32, 64'd4096 << 48};
        rebuild_normal_matrix();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes of every field under the reset identity
        ext = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, -32'sh1};
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
            begin
                v = '{ext[i], ext[j], ext[(i+j)%4], ext[(i+1)%4],
                      ext[j], ext[(j+1)%4], ext[(i+2)%4], logic'((i+j)%2)};
                vertex_backlog.push_back(v);
            end
        vertex_backlog.push_back('{32'sh0000_0800, -32'sh800, 32'sh1_8000, 32'sh1_0000,
                                   32'sh8000, -32'sh8000, 32'sh1, 1'b1});
        drain();

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: r = '{fill_row(16'h7fff), fill_row(16'h7fff),
                         fill_row(16'h7fff), fill_row(16'h7fff)};
                1: r = '{fill_row(16'h8000), fill_row(16'h8000),
                         fill_row(16'h8000), fill_row(16'h8000)};
                2: r = '{64'h0000_0000_0000_7fff, 64'h0000_0000_8000_0000,
                         64'h0000_7fff_0000_0000, 64'h8000_0000_0000_0000};
                3: r = '{64'h0000_0000_0000_0001, 64'h0000_0000_0001_0000,
                         64'h0000_0001_0000_0000, 64'hffff_ffff_ffff_ffff};
                default:
                begin
                    for (int k = 0; k < 4; k++)
                        r[k] = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
                    if (ph == 5)
                        r[ROW2] = r[ROW0];
                end
            endcase
            write_row(ROW0, r[ROW0]);
            write_row(ROW1, r[ROW1]);
            write_row(ROW2, r[ROW2]);
            write_row(ROW3, r[ROW3]);
            if (ph == 6)
                squeeze_req = 1'b1;
            for (int k = 0; k < 105; k++)
                vertex_backlog.push_back(rand_vertex());
            drain();
        end

        if (fail_count == 0)
            $display("vertex_normal_transform_core verification clean");
        else
            $display("vertex_normal_transform_core verification failed");
        $finish;
    end
endmodule

// File: vertex_normal_transform_core.f
+incdir+sv
sv/vnt_pkg.sv
sv/vnt_derive.sv
sv/vertex_normal_transform_core.sv
bench/tb_vertex_normal_transform_core.sv
